// ===== rtl/dpdc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dpdc_pkg - shared types and constants for the dual PID drive controller
// Field widths, gain reset values, register indexes and the transaction types
// passed between the error stage and the top level.
// ----------------------------------------------------------------------------
package dpdc_pkg;

    // field widths
    localparam int PosW   = 24;            // wheel position
    localparam int HeadW  = 21;            // gyro heading, 1/64 degree
    localparam int GainW  = 24;            // unsigned Q8.16 gain
    localparam int PctW   = 8;             // motor command percent
    localparam int CfgIdxW = 3;

    // derived widths of the working values
    localparam int ErrW    = PosW + 1;     // distance error
    localparam int DErrW   = ErrW + 1;     // distance error delta
    localparam int HNumW   = HeadW + 3;    // 2*target - h1 - h2
    localparam int HeadShift = 7;          // 1/64 degree sum of two -> degrees
    localparam int HErrW   = HNumW - HeadShift; // heading error, whole degrees
    localparam int HDErrW  = HErrW + 1;
    localparam int SumW    = 32;           // saturating integrators
    localparam int ShW     = HeadW + 1;    // start heading (sum of both readings)
    localparam int FfDiffW = ShW + 2;      // 2*target - start heading

    // datapath widths
    localparam int AccW  = SumW + GainW + 2;
    localparam int QFrac = 16;
    localparam int LatW  = 25;             // lateral power, Q.16, within +-100
    localparam int TurnW = QFrac + 10;     // turn power after pre-saturation
    localparam int DrvW  = TurnW + 1;      // lateral +- turn

    // Q.16 limits
    localparam int QOne     = 1 << QFrac;
    localparam int PctMax   = 100;
    localparam int LatMaxQ  = PctMax * QOne;
    localparam int SlewQ    = 15 * QOne;
    // beyond this the wheel command saturates whatever the lateral term is
    localparam int TurnLimQ = 1 << (QFrac + 8);

    // settle and integral windows
    localparam int DistTol      = 50;
    localparam int HeadTol      = 3;
    localparam int HeadIntLimit = 45;

    // feedforward: x * 64 / 125 == floor(x * FfRecip / 2^FfRecipShift)
    // for |x| <= 2^22; FfRecip = ceil(2^35 / 125), error term 7 * 2^28 < 2^35
    localparam int FfRecipW     = 29;
    localparam int FfRecipShift = 29;
    localparam logic [FfRecipW-1:0] FfRecip = 29'd274877907;

    // gain reset values
    localparam logic [GainW-1:0] DrivePReset = 24'd4588;
    localparam logic [GainW-1:0] DriveIReset = 24'd0;
    localparam logic [GainW-1:0] DriveDReset = 24'd0;
    localparam logic [GainW-1:0] TurnPReset  = 24'd26477;
    localparam logic [GainW-1:0] TurnIReset  = 24'd0;
    localparam logic [GainW-1:0] TurnDReset  = 24'd6554;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TARGET_DISTANCE = 3'd0,
        CFG_TARGET_HEADING  = 3'd1,
        CFG_DRIVE_P_GAIN    = 3'd2,
        CFG_DRIVE_I_GAIN    = 3'd3,
        CFG_DRIVE_D_GAIN    = 3'd4,
        CFG_TURN_P_GAIN     = 3'd5,
        CFG_TURN_I_GAIN     = 3'd6,
        CFG_TURN_D_GAIN     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic                    restart;
        logic signed [PosW-1:0]  left_position;
        logic signed [PosW-1:0]  right_position;
        logic signed [HeadW-1:0] heading_first;
        logic signed [HeadW-1:0] heading_second;
    } t_item;

    typedef struct packed {
        logic signed [ErrW-1:0]    dist_err;
        logic signed [DErrW-1:0]   dist_derr;
        logic signed [SumW-1:0]    dist_sum;
        logic signed [HErrW-1:0]   head_err;
        logic signed [HDErrW-1:0]  head_derr;
        logic signed [SumW-1:0]    head_sum;
        logic signed [FfDiffW-1:0] ff_diff;
        logic                      settled;
    } t_err;

    function automatic logic signed [SumW-1:0] sat_sum(input logic signed [SumW:0] v);
        logic signed [SumW-1:0] r;
        if (v[SumW] != v[SumW-1]) begin
            r = v[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
        end else begin
            r = v[SumW-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/dpdc_err.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dpdc_err - error and integrator stage
// Forms the distance and heading errors, their deltas and saturating sums,
// the feedforward difference and the settled flag; holds the loop history.
// ----------------------------------------------------------------------------
module dpdc_err (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  dpdc_pkg::t_item                     i_item,
    input  logic signed [dpdc_pkg::PosW-1:0]    i_target_distance,
    input  logic signed [dpdc_pkg::HeadW-1:0]   i_target_heading,
    output dpdc_pkg::t_err                      o_err
);
    import dpdc_pkg::*;

    logic signed [ErrW-1:0]    r_last_dist_err;
    logic signed [SumW-1:0]    r_dist_sum;
    logic signed [HErrW-1:0]   r_last_head_err;
    logic signed [SumW-1:0]    r_head_sum;
    logic signed [ShW-1:0]     r_start_heading;

    logic signed [ErrW-1:0]    pos_sum;
    logic signed [ErrW-1:0]    pos_sum_adj;
    logic signed [ErrW-1:0]    pos_mean;
    logic signed [ErrW-1:0]    dist_err;
    logic        [ErrW-1:0]    dist_abs;
    logic signed [SumW:0]      dist_sum_wide;
    logic signed [SumW-1:0]    n_dist_sum;

    logic signed [HNumW-1:0]   head_num;
    logic signed [HNumW-1:0]   head_num_adj;
    logic signed [HErrW-1:0]   head_err;
    logic        [HErrW-1:0]   head_abs;
    logic signed [SumW-1:0]    head_sum_base;
    logic signed [SumW:0]      head_sum_wide;
    logic signed [SumW-1:0]    n_head_sum;

    logic signed [ShW-1:0]     head_pair;
    logic signed [ShW-1:0]     n_start_heading;
    logic                      settled;

    // distance: mean of the wheels, truncated toward zero
    assign pos_sum     = ErrW'(i_item.left_position) + ErrW'(i_item.right_position);
    assign pos_sum_adj = pos_sum + {{(ErrW-1){1'b0}}, pos_sum[ErrW-1]};
    assign pos_mean    = pos_sum_adj >>> 1;
    assign dist_err    = ErrW'(i_target_distance) - pos_mean;
    assign dist_abs    = dist_err[ErrW-1] ? ErrW'(-dist_err) : dist_err;

    assign dist_sum_wide = (SumW+1)'(r_dist_sum) + (SumW+1)'(dist_err);
    assign n_dist_sum    = sat_sum(dist_sum_wide);

    // heading: mean of both readings in whole degrees, truncated toward zero
    assign head_num = HNumW'($signed({i_target_heading, 1'b0}))
                    - HNumW'(i_item.heading_first) - HNumW'(i_item.heading_second);
    assign head_num_adj = head_num
                        + (head_num[HNumW-1] ? HNumW'((1 << HeadShift) - 1) : HNumW'(0));
    assign head_err = HErrW'(head_num_adj >>> HeadShift);
    assign head_abs = head_err[HErrW-1] ? HErrW'(-head_err) : head_err;

    // integral restarts on zero error or outside the capture window
    assign head_sum_base = (head_err == '0 || head_abs > HErrW'(HeadIntLimit))
                         ? '0 : r_head_sum;
    assign head_sum_wide = (SumW+1)'(head_sum_base) + (SumW+1)'(head_err);
    assign n_head_sum    = sat_sum(head_sum_wide);

    assign head_pair       = ShW'(i_item.heading_first) + ShW'(i_item.heading_second);
    assign n_start_heading = i_item.restart ? head_pair : r_start_heading;

    assign settled = (head_abs <= HErrW'(HeadTol)) && (dist_abs < ErrW'(DistTol));

    always_comb begin
        o_err.dist_err  = dist_err;
        o_err.dist_derr = DErrW'(dist_err) - DErrW'(r_last_dist_err);
        o_err.dist_sum  = n_dist_sum;
        o_err.head_err  = head_err;
        o_err.head_derr = HDErrW'(head_err) - HDErrW'(r_last_head_err);
        o_err.head_sum  = n_head_sum;
        o_err.ff_diff   = FfDiffW'($signed({i_target_heading, 1'b0}))
                        - FfDiffW'(n_start_heading);
        o_err.settled   = settled;
    end

    // the settled case only advances the distance sum and the start heading
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_dist_err <= '0;
            r_dist_sum      <= '0;
            r_last_head_err <= '0;
            r_head_sum      <= '0;
            r_start_heading <= '0;
        end else if (i_adv) begin
            r_dist_sum      <= n_dist_sum;
            r_start_heading <= n_start_heading;
            if (!settled) begin
                r_last_dist_err <= dist_err;
                r_last_head_err <= head_err;
                r_head_sum      <= n_head_sum;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dual_pid_drive_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dual_pid_drive_controller - distance and heading PID with slewed lateral
// Six-register pipeline: input, errors, gain products, sums, lateral clamp
// and slew, wheel commands. One result transaction per input transaction.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the result stream is ready; the
// integrators close within the error stage and the slew limiter closes within
// the lateral stage, so neither loop holds the next transaction back.
// Reset (synchronous, active low): pipeline empty, loop history zero, config
// registers at their reset values. Per-stage ready lets bubbles collapse.
module dual_pid_drive_controller (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic [dpdc_pkg::CfgIdxW-1:0]           i_cfg_addr,
    input  logic [dpdc_pkg::GainW-1:0]             i_cfg_data,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: left_position[23:0], right_position[47:24], heading_first[68:48],
    //        heading_second[89:69], zero padding[95:90]
    input  logic [95:0]                            s_axis_tdata,
    input  logic                                   s_axis_tuser,  // restart
    // result stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata: left_drive[7:0], right_drive[15:8]
    output logic [15:0]                            m_axis_tdata,
    output logic                                   m_axis_tuser   // done_res
);
    import dpdc_pkg::*;

    localparam int PdW  = ErrW + GainW + 1;
    localparam int PddW = DErrW + GainW + 1;
    localparam int PhW  = HErrW + GainW + 1;
    localparam int PhdW = HDErrW + GainW + 1;
    localparam int PiW  = SumW + GainW + 1;
    localparam int FfProdW = FfDiffW + FfRecipW;

    // configuration registers
    logic signed [PosW-1:0]  r_target_distance;
    logic signed [HeadW-1:0] r_target_heading;
    logic [GainW-1:0] r_drive_p_gain, r_drive_i_gain, r_drive_d_gain;
    logic [GainW-1:0] r_turn_p_gain, r_turn_i_gain, r_turn_d_gain;

    // stage valids and readies
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage payloads
    t_item r_item;
    t_err  err_next;
    t_err  r_err;

    logic signed [PdW-1:0]  r_p_dist;
    logic signed [PddW-1:0] r_p_dist_d;
    logic signed [PiW-1:0]  r_p_dist_i;
    logic signed [PhW-1:0]  r_p_head;
    logic signed [PhdW-1:0] r_p_head_d;
    logic signed [PiW-1:0]  r_p_head_i;
    logic [FfProdW-1:0]     r_ff_prod;
    logic                   r_ff_neg;
    logic                   r_settled2;

    logic signed [AccW-1:0] r_lat3;
    logic signed [AccW-1:0] r_turn3;
    logic                   r_settled3;

    logic signed [LatW-1:0]  r_last_lat;
    logic signed [LatW-1:0]  r_lat4;
    logic signed [TurnW-1:0] r_turn4;
    logic                    r_settled4;

    logic signed [PctW-1:0] r_left_drive, r_right_drive;
    logic                   r_done;

    logic [FfDiffW-1:0]      ff_abs;
    logic signed [AccW-1:0]  ff_val;
    logic signed [LatW-1:0]  lat_clamp;
    logic signed [LatW:0]    lat_step;
    logic signed [LatW-1:0]  n_lat;
    logic signed [TurnW-1:0] n_turn;
    logic signed [DrvW-1:0]  left_sum, right_sum;

    function automatic logic signed [PctW-1:0] to_pct(input logic signed [DrvW-1:0] x);
        logic signed [DrvW-1:0]       adj;
        logic signed [DrvW-QFrac-1:0] p;
        logic signed [PctW-1:0]       r;
        adj = x + (x[DrvW-1] ? DrvW'(QOne - 1) : DrvW'(0));
        p   = (DrvW-QFrac)'(adj >>> QFrac);
        if (p > PctMax) begin
            r = PctW'(PctMax);
        end else if (p < -PctMax) begin
            r = PctW'(-PctMax);
        end else begin
            r = PctW'(p);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_distance <= '0;
            r_target_heading  <= '0;
            r_drive_p_gain    <= DrivePReset;
            r_drive_i_gain    <= DriveIReset;
            r_drive_d_gain    <= DriveDReset;
            r_turn_p_gain     <= TurnPReset;
            r_turn_i_gain     <= TurnIReset;
            r_turn_d_gain     <= TurnDReset;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_TARGET_DISTANCE: r_target_distance <= i_cfg_data[PosW-1:0];
                CFG_TARGET_HEADING:  r_target_heading  <= i_cfg_data[HeadW-1:0];
                CFG_DRIVE_P_GAIN:    r_drive_p_gain    <= i_cfg_data;
                CFG_DRIVE_I_GAIN:    r_drive_i_gain    <= i_cfg_data;
                CFG_DRIVE_D_GAIN:    r_drive_d_gain    <= i_cfg_data;
                CFG_TURN_P_GAIN:     r_turn_p_gain     <= i_cfg_data;
                CFG_TURN_I_GAIN:     r_turn_i_gain     <= i_cfg_data;
                CFG_TURN_D_GAIN:     r_turn_d_gain     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // flow control: a stage loads when it is empty or its content moves on
    // ------------------------------------------------------------------
    assign rdy5 = !r_v5 || m_axis_tready;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;

    assign s_axis_tready = rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy0) r_v0 <= s_axis_tvalid;
            if (rdy1) r_v1 <= r_v0;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // ------------------------------------------------------------------
    // stage 0: input register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_item.restart        <= s_axis_tuser;
            r_item.left_position  <= s_axis_tdata[PosW-1:0];
            r_item.right_position <= s_axis_tdata[2*PosW-1:PosW];
            r_item.heading_first  <= s_axis_tdata[2*PosW +: HeadW];
            r_item.heading_second <= s_axis_tdata[2*PosW+HeadW +: HeadW];
        end
    end

    // ------------------------------------------------------------------
    // stage 1: errors and integrators
    // ------------------------------------------------------------------
    dpdc_err u_err (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_adv             (r_v0 && rdy1),
        .i_item            (r_item),
        .i_target_distance (r_target_distance),
        .i_target_heading  (r_target_heading),
        .o_err             (err_next)
    );

    always_ff @(posedge i_clk) begin
        if (rdy1) r_err <= err_next;
    end

    // ------------------------------------------------------------------
    // stage 2: gain products and feedforward reciprocal
    // ------------------------------------------------------------------
    assign ff_abs = r_err.ff_diff[FfDiffW-1] ? FfDiffW'(-r_err.ff_diff) : r_err.ff_diff;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_p_dist   <= $signed(r_err.dist_err)  * $signed({1'b0, r_drive_p_gain});
            r_p_dist_d <= $signed(r_err.dist_derr) * $signed({1'b0, r_drive_d_gain});
            r_p_dist_i <= $signed(r_err.dist_sum)  * $signed({1'b0, r_drive_i_gain});
            r_p_head   <= $signed(r_err.head_err)  * $signed({1'b0, r_turn_p_gain});
            r_p_head_d <= $signed(r_err.head_derr) * $signed({1'b0, r_turn_d_gain});
            r_p_head_i <= $signed(r_err.head_sum)  * $signed({1'b0, r_turn_i_gain});
            r_ff_prod  <= ff_abs * FfRecip;
            r_ff_neg   <= r_err.ff_diff[FfDiffW-1];
            r_settled2 <= r_err.settled;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: lateral and turn sums
    // ------------------------------------------------------------------
    always_comb begin
        ff_val = AccW'($signed({1'b0, r_ff_prod[FfRecipShift +: FfDiffW]}));
        if (r_ff_neg) ff_val = -ff_val;
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_lat3  <= AccW'(r_p_dist) + AccW'(r_p_dist_d) + AccW'(r_p_dist_i);
            r_turn3 <= AccW'(r_p_head) + AccW'(r_p_head_d) + AccW'(r_p_head_i) + ff_val;
            r_settled3 <= r_settled2;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: clamp and slew the lateral power, pre-saturate turn
    // ------------------------------------------------------------------
    always_comb begin
        if (r_lat3 > LatMaxQ) begin
            lat_clamp = LatW'(LatMaxQ);
        end else if (r_lat3 < -LatMaxQ) begin
            lat_clamp = LatW'(-LatMaxQ);
        end else begin
            lat_clamp = LatW'(r_lat3);
        end
        lat_step = (LatW+1)'(lat_clamp) - (LatW+1)'(r_last_lat);
        n_lat = lat_clamp;
        if (lat_clamp > 0 && lat_step > SlewQ) begin
            n_lat = r_last_lat + LatW'(SlewQ);
        end else if (lat_clamp < 0 && lat_step < -SlewQ) begin
            n_lat = r_last_lat - LatW'(SlewQ);
        end

        if (r_turn3 > TurnLimQ) begin
            n_turn = TurnW'(TurnLimQ);
        end else if (r_turn3 < -TurnLimQ) begin
            n_turn = TurnW'(-TurnLimQ);
        end else begin
            n_turn = TurnW'(r_turn3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_lat <= '0;
        end else if (r_v3 && rdy4 && !r_settled3) begin
            r_last_lat <= n_lat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_lat4     <= n_lat;
            r_turn4    <= n_turn;
            r_settled4 <= r_settled3;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: wheel commands, output register
    // ------------------------------------------------------------------
    assign left_sum  = DrvW'(r_lat4) + DrvW'(r_turn4);
    assign right_sum = DrvW'(r_lat4) - DrvW'(r_turn4);

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            if (r_settled4) begin
                r_left_drive  <= '0;
                r_right_drive <= '0;
                r_done        <= 1'b1;
            end else begin
                r_left_drive  <= to_pct(left_sum);
                r_right_drive <= to_pct(right_sum);
                r_done        <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_v5;
    assign m_axis_tdata  = {r_right_drive, r_left_drive};
    assign m_axis_tuser  = r_done;

endmodule
`default_nettype wire

// ===== tb/tb_dual_pid_drive_controller.sv =====
// ----------------------------------------------------------------------------
// tb_dual_pid_drive_controller - self-checking bench for the drive controller
// Drives wheel and gyro ticks on the input stream, predicts every wheel
// command from a fixed-point mirror of both PID loops, and checks each
// result transaction in order. Directed ticks cover field extremes,
// the settle window and the heading integral window; random phases run
// well-formed moves with extreme or random gains, plus noise, mostly under random backpressure.
// ----------------------------------------------------------------------------
module tb_dual_pid_drive_controller;
    import dpdc_pkg::*;

    localparam int CycleLimit  = 400000;
    localparam int DrainCycles = 16;
    localparam int MaxReports  = 10;

    typedef struct packed {
        logic [PctW-1:0] left_drive;
        logic [PctW-1:0] right_drive;
        logic            done_res;
    } t_drive_cmd;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_addr;
    logic [GainW-1:0]    i_cfg_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [95:0]         s_axis_tdata;   // left[23:0] right[47:24] h1[68:48] h2[89:69]
    logic                s_axis_tuser;   // restart
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [15:0]         m_axis_tdata;   // left_drive[7:0] right_drive[15:8]
    logic                m_axis_tuser;   // done_res

    dual_pid_drive_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // controller mirror: configuration and loop history
    longint tgt_dist, tgt_head;
    longint kp_dist, ki_dist, kd_dist, kp_turn, ki_turn, kd_turn;
    longint prev_dist_err, dist_err_sum, prev_head_err, head_err_sum;
    longint start_head, prev_lat;

    t_drive_cmd expected_cmd_q[$];
    t_drive_cmd want_cmd, got_cmd;
    int         error_count = 0;
    int         result_count = 0;
    int         ticks_sent = 0;
    int         cycle_count = 0;
    bit         idle_en = 1'b0;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    task automatic reset_mirror();
        tgt_dist = 0;
        tgt_head = 0;
        kp_dist  = longint'(DrivePReset);
        ki_dist  = longint'(DriveIReset);
        kd_dist  = longint'(DriveDReset);
        kp_turn  = longint'(TurnPReset);
        ki_turn  = longint'(TurnIReset);
        kd_turn  = longint'(TurnDReset);
        prev_dist_err = 0;
        dist_err_sum  = 0;
        prev_head_err = 0;
        head_err_sum  = 0;
        start_head    = 0;
        prev_lat      = 0;
    endtask

    function automatic longint clamp_i32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [PctW-1:0] to_percent(input longint q);
        longint p;
        p = q / QOne;
        if (p > PctMax) p = PctMax;
        if (p < -PctMax) p = -PctMax;
        return p[PctW-1:0];
    endfunction

    task automatic predict_tick(input t_item it);
        longint lp, rp, h1, h2, e, de, he, dh, lat, turn, ff, ae, ah;
        t_drive_cmd cmd;
        lp = longint'($signed(it.left_position));
        rp = longint'($signed(it.right_position));
        h1 = longint'($signed(it.heading_first));
        h2 = longint'($signed(it.heading_second));

        if (it.restart) start_head = h1 + h2;

        e  = tgt_dist - (lp + rp) / 2;
        de = e - prev_dist_err;
        dist_err_sum = clamp_i32(dist_err_sum + e);
        lat = e * kp_dist + de * kd_dist + dist_err_sum * ki_dist;

        he = (2 * tgt_head - h1 - h2) / 128;
        ae = (e < 0) ? -e : e;
        ah = (he < 0) ? -he : he;

        if (ah <= HeadTol && ae < DistTol) begin
            // settled: zero drive, rest of the history held
            cmd.left_drive  = '0;
            cmd.right_drive = '0;
            cmd.done_res    = 1'b1;
        end else begin
            dh = he - prev_head_err;
            if (he == 0 || ah > HeadIntLimit) head_err_sum = 0;
            head_err_sum = clamp_i32(head_err_sum + he);
            ff = ((2 * tgt_head - start_head) * 64) / 125;
            turn = he * kp_turn + dh * kd_turn + head_err_sum * ki_turn + ff;

            if (lat > LatMaxQ) lat = LatMaxQ;
            if (lat < -LatMaxQ) lat = -LatMaxQ;
            if (lat > 0 && lat - prev_lat > SlewQ) lat = prev_lat + SlewQ;
            if (lat < 0 && lat - prev_lat < -SlewQ) lat = prev_lat - SlewQ;
            prev_lat = lat;

            cmd.left_drive  = to_percent(lat + turn);
            cmd.right_drive = to_percent(lat - turn);
            cmd.done_res    = 1'b0;
            prev_dist_err   = e;
            prev_head_err   = he;
        end
        expected_cmd_q.push_back(cmd);
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string field, input int want_v, input int got_v);
        error_count++;
        if (error_count <= MaxReports)
            $display("result %0d: %s expected %0d got %0d", result_count, field,
                     want_v, got_v);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_cmd.left_drive  = m_axis_tdata[7:0];
            got_cmd.right_drive = m_axis_tdata[15:8];
            got_cmd.done_res    = m_axis_tuser;
            if (expected_cmd_q.size() == 0) begin
                error_count++;
                if (error_count <= MaxReports)
                    $display("result %0d: unexpected transaction, data %h done %b",
                             result_count, m_axis_tdata, m_axis_tuser);
            end else begin
                want_cmd = expected_cmd_q.pop_front();
                if (got_cmd.left_drive !== want_cmd.left_drive)
                    flag_mismatch("left_drive", int'($signed(want_cmd.left_drive)),
                                  int'($signed(got_cmd.left_drive)));
                if (got_cmd.right_drive !== want_cmd.right_drive)
                    flag_mismatch("right_drive", int'($signed(want_cmd.right_drive)),
                                  int'($signed(got_cmd.right_drive)));
                if (got_cmd.done_res !== want_cmd.done_res)
                    flag_mismatch("done_res", int'(want_cmd.done_res),
                                  int'(got_cmd.done_res));
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver backpressure: random stall bursts while idling is enabled
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_en && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_item mk_item(input logic rs, input longint lp, input longint rp,
                                      input longint h1, input longint h2);
        t_item it;
        it.restart        = rs;
        it.left_position  = lp[PosW-1:0];
        it.right_position = rp[PosW-1:0];
        it.heading_first  = h1[HeadW-1:0];
        it.heading_second = h2[HeadW-1:0];
        return it;
    endfunction

    function automatic longint rand_offset(input int span);
        return longint'(int'($urandom_range(0, 2 * span))) - span;
    endfunction

    // entered and left on a falling edge
    task automatic send_tick(input t_item it);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.restart;
        s_axis_tdata  <= {6'd0, it.heading_second, it.heading_first,
                          it.right_position, it.left_position};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_tick(it);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (expected_cmd_q.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [GainW-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_TARGET_DISTANCE: tgt_dist = longint'($signed(value[PosW-1:0]));
            CFG_TARGET_HEADING:  tgt_head = longint'($signed(value[HeadW-1:0]));
            CFG_DRIVE_P_GAIN:    kp_dist  = longint'({40'd0, value});
            CFG_DRIVE_I_GAIN:    ki_dist  = longint'({40'd0, value});
            CFG_DRIVE_D_GAIN:    kd_dist  = longint'({40'd0, value});
            CFG_TURN_P_GAIN:     kp_turn  = longint'({40'd0, value});
            CFG_TURN_I_GAIN:     ki_turn  = longint'({40'd0, value});
            CFG_TURN_D_GAIN:     kd_turn  = longint'({40'd0, value});
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    function automatic logic [GainW-1:0] heading_word(input logic [HeadW-1:0] v);
        return {{(GainW-HeadW){v[HeadW-1]}}, v};
    endfunction

    function automatic logic [GainW-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            5:       return GainW'($urandom());
            default: return GainW'($urandom_range(0, 40000));
        endcase
    endfunction

    function automatic logic [PosW-1:0] pick_target_distance();
        case ($urandom_range(0, 5))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            5:       return PosW'($urandom());
            default: return PosW'(rand_offset(20000));
        endcase
    endfunction

    function automatic logic [HeadW-1:0] pick_target_heading();
        case ($urandom_range(0, 5))
            0:       return 21'h0FFFFF;
            1:       return 21'h100000;
            5:       return HeadW'($urandom());
            default: return HeadW'(rand_offset(64 * 720));
        endcase
    endfunction

    // one move: restart, wheels ramp to the target, headings close in and settle
    task automatic run_move(input int steps);
        longint mean;
        int span_p, span_h;
        for (int s = 0; s < steps; s++) begin
            span_p = (s >= steps - 3) ? 20 : 500;
            span_h = (s >= steps - 3) ? 90 : 4000;
            mean = tgt_dist * (s + 1) / steps;
            send_tick(mk_item(s == 0, mean + rand_offset(span_p), mean + rand_offset(span_p),
                              tgt_head + rand_offset(span_h),
                              tgt_head + rand_offset(span_h)));
        end
    endtask

    task automatic send_noise_tick();
        send_tick(mk_item(1'($urandom_range(0, 1)), longint'($urandom()),
                          longint'($urandom()), longint'($urandom()),
                          longint'($urandom())));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_tick(mk_item(1'b1, 0, 0, 0, 0));          // settled from reset
        send_tick(mk_item(1'b0, 1000, 1000, 0, 0));    // negative slew step
        send_tick(mk_item(1'b0, 1000, 1000, 0, 0));
        send_tick(mk_item(1'b0, 1000, 1000, 640, 640));
    endtask

    task automatic test_field_extremes();
        send_tick(mk_item(1'b1, 24'h7FFFFF, 24'h7FFFFF, 21'h0FFFFF, 21'h0FFFFF));
        send_tick(mk_item(1'b1, -8388608, -8388608, -1048576, -1048576));
        // odd wheel sum and odd heading sum: both round toward zero
        send_tick(mk_item(1'b0, 8388607, -8388608, 1048575, -1048576));
        send_tick(mk_item(1'b0, -3, 0, -300, -300));
        send_tick(mk_item(1'b0, 0, 0, 0, 0));
        send_tick(mk_item(1'b0, 8388607, 8388607, 1048575, 1048575));
        send_tick(mk_item(1'b1, -100, -101, 1048575, 0));
        send_tick(mk_item(1'b0, longint'($urandom()), longint'($urandom()),
                          longint'($urandom()), longint'($urandom())));
    endtask

    task automatic test_settle_window();
        send_tick(mk_item(1'b0, -49, -49, -192, -192));   // e 49, h 3
        send_tick(mk_item(1'b0, -50, -50, -192, -192));   // e 50
        send_tick(mk_item(1'b0, 49, 49, 192, 192));       // e -49, h -3
        send_tick(mk_item(1'b0, 49, 49, 256, 256));       // h -4
        send_tick(mk_item(1'b0, 0, 0, -127, 0));          // h rounds to 0
        send_tick(mk_item(1'b0, 0, 0, 0, 0));
    endtask

    task automatic test_heading_integral();
        drain_pipeline();
        write_reg(CFG_TURN_I_GAIN, 24'd131072);
        send_tick(mk_item(1'b0, -1000, -1000, -640, -640));     // h 10
        send_tick(mk_item(1'b0, -1000, -1000, -640, -640));
        send_tick(mk_item(1'b0, -1000, -1000, 0, 0));           // zero error clears
        send_tick(mk_item(1'b0, -1000, -1000, -2880, -2880));   // h 45 kept
        send_tick(mk_item(1'b0, -1000, -1000, -2880, -2880));
        send_tick(mk_item(1'b0, -1000, -1000, 2944, 2944));     // h -46 clears
    endtask

    task automatic test_sum_saturation();
        drain_pipeline();
        write_reg(CFG_TARGET_DISTANCE, 24'h7FFFFF);
        write_reg(CFG_DRIVE_P_GAIN, '0);
        write_reg(CFG_DRIVE_I_GAIN, 24'd1);
        write_reg(CFG_DRIVE_D_GAIN, '0);
        repeat (140) send_tick(mk_item(1'b0, -8388608, -8388608,
                                       rand_offset(5000), rand_offset(5000)));
        // reverse: the integrator unwinds from its positive limit
        drain_pipeline();
        write_reg(CFG_TARGET_DISTANCE, 24'h800000);
        repeat (140) send_tick(mk_item(1'b0, 8388607, 8388607,
                                       rand_offset(5000), rand_offset(5000)));
    endtask

    task automatic configure_phase(input int phase);
        drain_pipeline();
        if (phase == 0) begin
            write_reg(CFG_TARGET_DISTANCE, 24'h7FFFFF);
            write_reg(CFG_TARGET_HEADING, heading_word(21'h0FFFFF));
            write_reg(CFG_DRIVE_P_GAIN, '1);
            write_reg(CFG_DRIVE_I_GAIN, '1);
            write_reg(CFG_DRIVE_D_GAIN, '1);
            write_reg(CFG_TURN_P_GAIN, '1);
            write_reg(CFG_TURN_I_GAIN, '1);
            write_reg(CFG_TURN_D_GAIN, '1);
        end else if (phase == 1) begin
            write_reg(CFG_TARGET_DISTANCE, 24'h800000);
            write_reg(CFG_TARGET_HEADING, heading_word(21'h100000));
            write_reg(CFG_DRIVE_P_GAIN, '0);
            write_reg(CFG_DRIVE_I_GAIN, '0);
            write_reg(CFG_DRIVE_D_GAIN, '0);
            write_reg(CFG_TURN_P_GAIN, '0);
            write_reg(CFG_TURN_I_GAIN, '0);
            write_reg(CFG_TURN_D_GAIN, '0);
        end else begin
            write_reg(CFG_TARGET_DISTANCE, pick_target_distance());
            write_reg(CFG_TARGET_HEADING, heading_word(pick_target_heading()));
            write_reg(CFG_DRIVE_P_GAIN, pick_gain());
            write_reg(CFG_DRIVE_I_GAIN, pick_gain());
            write_reg(CFG_DRIVE_D_GAIN, pick_gain());
            write_reg(CFG_TURN_P_GAIN, pick_gain());
            write_reg(CFG_TURN_I_GAIN, pick_gain());
            write_reg(CFG_TURN_D_GAIN, pick_gain());
        end
    endtask

    task automatic test_random_moves();
        int phase_end;
        for (int phase = 0; phase < 11; phase++) begin
            configure_phase(phase);
            phase_end = ticks_sent + 130;
            while (ticks_sent < phase_end) begin
                // final phase runs flat out
                idle_en = (phase == 10) ? 1'b0 : ($urandom_range(0, 4) != 0);
                if ($urandom_range(0, 6) == 0)
                    repeat ($urandom_range(1, 4)) send_noise_tick();
                else
                    run_move($urandom_range(6, 40));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_TARGET_DISTANCE;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        reset_mirror();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_en = 1'b1;
        test_reset_defaults();
        test_field_extremes();
        test_settle_window();
        test_heading_integral();
        test_sum_saturation();
        test_random_moves();
        drain_pipeline();

        if (error_count == 0 && expected_cmd_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== dual_pid_drive_controller.f =====
rtl/dpdc_pkg.sv
rtl/dpdc_err.sv
rtl/dual_pid_drive_controller.sv
tb/tb_dual_pid_drive_controller.sv
